// File: hw/rtl/thc_pkg.sv
`default_nettype none

package thc_pkg;

  localparam int NUM_STAGES = 15;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic signed [31:0] HUM_FINE_OFS  = 32'sd76800;
  localparam logic signed [31:0] HUM_CLAMP_MAX = 32'sd419430400;
  localparam logic signed [31:0] HUM_BASE      = 32'sd2097152;
  localparam logic signed [31:0] HUM_ROUND_A   = 32'sd16384;
  localparam logic signed [31:0] HUM_SCALE_ADD = 32'sd32768;
  localparam logic signed [31:0] HUM_ROUND_B   = 32'sd8192;
  localparam logic signed [31:0] TEMP_ROUND    = 32'sd128;
  localparam logic signed [31:0] TEMP_MAX      = 32'sd32767;
  localparam logic signed [31:0] TEMP_MIN      = -32'sd32768;
  localparam logic [16:0]        HUM_Q_MAX     = 17'd102400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_CAL_ONE     = 4'd0,
    REG_TEMP_CAL_TWO     = 4'd1,
    REG_TEMP_CAL_THREE   = 4'd2,
    REG_HUM_CAL_ONE      = 4'd3,
    REG_HUM_CAL_TWO      = 4'd4,
    REG_HUM_CAL_THREE    = 4'd5,
    REG_HUM_CAL_FOUR_FIVE = 4'd6,
    REG_HUM_CAL_SIX      = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } thc_in_t;

  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [15:0] temperature_centi;
    logic [16:0]        humidity_q10;
  } thc_out_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [7:0]         h1;
    logic signed [15:0] h2;
    logic [7:0]         h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } thc_cal_t;

endpackage

`default_nettype wire

// File: hw/rtl/thc_cfg_regs.sv
`default_nettype none

module thc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [thc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [thc_pkg::CFG_DATA_W-1:0] cfg_data,
  output thc_pkg::thc_cal_t                   cal
);
  import thc_pkg::*;

  thc_cal_t cal_r;
  thc_cal_t cal_nxt;

  assign cfg_ready = 1'b1;
  assign cal       = cal_r;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_TEMP_CAL_ONE:      cal_nxt.t1 = cfg_data[15:0];
        REG_TEMP_CAL_TWO:      cal_nxt.t2 = cfg_data[15:0];
        REG_TEMP_CAL_THREE:    cal_nxt.t3 = cfg_data[15:0];
        REG_HUM_CAL_ONE:       cal_nxt.h1 = cfg_data[7:0];
        REG_HUM_CAL_TWO:       cal_nxt.h2 = cfg_data[15:0];
        REG_HUM_CAL_THREE:     cal_nxt.h3 = cfg_data[7:0];
        REG_HUM_CAL_FOUR_FIVE: begin
          cal_nxt.h4 = cfg_data[11:0];
          cal_nxt.h5 = cfg_data[23:12];
        end
        REG_HUM_CAL_SIX:       cal_nxt.h6 = cfg_data[7:0];
        default:               cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/temp_humidity_compensation.sv
// Integer temperature and humidity compensation for a combined sensor.
// Calibration words are written through the cfg_ channel (index, data);
// writes are taken in every cycle and must only happen while no item is in
// flight. Each input item carries one raw temperature and one raw humidity
// conversion and produces exactly one result item: the fine temperature,
// the temperature in hundredths of a degree and the humidity in Q7.10.
// The datapath is a 15-stage pipeline with at most one 32-bit multiply level
// per stage; out_valid is the valid bit of the last stage. Throughput is
// one item per cycle while results are taken. Each stage carries its own
// valid bit and loads whenever it is empty or the stage after it moves, so
// bubbles close up and in_ready stays high while any stage is free, also
// while a result waits at the output. When the receiver stalls, results
// stay in place; in_ready falls only once all 15 stages hold items. Reset
// clears all valid bits and sets every calibration word to zero.
`default_nettype none

module temp_humidity_compensation (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire thc_pkg::thc_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output thc_pkg::thc_out_t                   out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [thc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [thc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import thc_pkg::*;

  thc_cal_t cal;

  thc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  logic signed [31:0] t1_x, t2_x, t3_x, h1_x, h2_x, h3_x, h4_x, h5_x, h6_x;

  assign t1_x = {16'd0, cal.t1};
  assign t2_x = {{16{cal.t2[15]}}, cal.t2};
  assign t3_x = {{16{cal.t3[15]}}, cal.t3};
  assign h1_x = {24'd0, cal.h1};
  assign h2_x = {{16{cal.h2[15]}}, cal.h2};
  assign h3_x = {24'd0, cal.h3};
  assign h4_x = {{20{cal.h4[11]}}, cal.h4};
  assign h5_x = {{20{cal.h5[11]}}, cal.h5};
  assign h6_x = {{24{cal.h6[7]}}, cal.h6};

  logic [1:NUM_STAGES]   v_r;
  logic [1:NUM_STAGES+1] rdy;
  logic [0:NUM_STAGES-1] vprev;

  always_comb begin
    rdy[NUM_STAGES+1] = out_ready;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign vprev    = {in_valid, v_r[1:NUM_STAGES-1]};
  assign in_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= vprev[k-1];
        end
      end
    end
  end

  logic signed [31:0] adc_t, adc_h_sh;
  logic [15:0]        adch_r [1:6];
  logic signed [31:0] fine_r [4:14];
  logic signed [15:0] tc_r   [6:14];

  assign adc_t = {12'd0, in_data.raw_temperature};

  logic signed [31:0] x1_r, d1_r;
  logic signed [31:0] p2_r, dd2_r;
  logic signed [31:0] a3_r, q3_r;
  logic signed [31:0] f5x_r, v5_r;
  logic signed [31:0] h5v6_r, vh66_r, vh36_r;
  logic signed [31:0] ah_r [7:11];
  logic signed [31:0] m17_r, m27_r;
  logic signed [31:0] b08_r, b19_r, b210_r, b311_r;
  logic signed [31:0] vv_r [12:14];
  logic signed [31:0] dsq13_r, e14_r;
  logic signed [31:0] tsh6, dq13, hum15, hum_rem;
  logic signed [15:0] tc6_nxt;
  logic [16:0]        q15_nxt;
  thc_out_t           out_r;

  assign adc_h_sh = {2'd0, adch_r[6], 14'd0};
  assign tsh6     = f5x_r >>> 8;
  assign dq13     = vv_r[12] >>> 15;
  assign hum15    = vv_r[14] - (e14_r >>> 4);

  always_comb begin
    if (tsh6 > TEMP_MAX) begin
      tc6_nxt = TEMP_MAX[15:0];
    end else if (tsh6 < TEMP_MIN) begin
      tc6_nxt = TEMP_MIN[15:0];
    end else begin
      tc6_nxt = tsh6[15:0];
    end
  end

  always_comb begin
    if (hum15 < 0) begin
      hum_rem = '0;
    end else if (hum15 > HUM_CLAMP_MAX) begin
      hum_rem = HUM_CLAMP_MAX;
    end else begin
      hum_rem = hum15;
    end
    q15_nxt = hum_rem[28:12];
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      x1_r      <= (adc_t >>> 3) - (t1_x <<< 1);
      d1_r      <= (adc_t >>> 4) - t1_x;
      adch_r[1] <= in_data.raw_humidity;
    end
    if (rdy[2]) begin
      p2_r      <= x1_r * t2_x;
      dd2_r     <= d1_r * d1_r;
      adch_r[2] <= adch_r[1];
    end
    if (rdy[3]) begin
      a3_r      <= p2_r >>> 11;
      q3_r      <= (dd2_r >>> 12) * t3_x;
      adch_r[3] <= adch_r[2];
    end
    if (rdy[4]) begin
      fine_r[4] <= a3_r + (q3_r >>> 14);
      adch_r[4] <= adch_r[3];
    end
    if (rdy[5]) begin
      fine_r[5] <= fine_r[4];
      f5x_r     <= (fine_r[4] <<< 2) + fine_r[4] + TEMP_ROUND;
      v5_r      <= fine_r[4] - HUM_FINE_OFS;
      adch_r[5] <= adch_r[4];
    end
    if (rdy[6]) begin
      fine_r[6] <= fine_r[5];
      tc_r[6]   <= tc6_nxt;
      h5v6_r    <= h5_x * v5_r;
      vh66_r    <= v5_r * h6_x;
      vh36_r    <= v5_r * h3_x;
      adch_r[6] <= adch_r[5];
    end
    if (rdy[7]) begin
      ah_r[7] <= (adc_h_sh - (h4_x <<< 20) - h5v6_r + HUM_ROUND_A) >>> 15;
      m17_r   <= vh66_r >>> 10;
      m27_r   <= (vh36_r >>> 11) + HUM_SCALE_ADD;
    end
    if (rdy[8]) begin
      ah_r[8] <= ah_r[7];
      b08_r   <= m17_r * m27_r;
    end
    if (rdy[9]) begin
      ah_r[9] <= ah_r[8];
      b19_r   <= (b08_r >>> 10) + HUM_BASE;
    end
    if (rdy[10]) begin
      ah_r[10] <= ah_r[9];
      b210_r   <= b19_r * h2_x;
    end
    if (rdy[11]) begin
      ah_r[11] <= ah_r[10];
      b311_r   <= (b210_r + HUM_ROUND_B) >>> 14;
    end
    if (rdy[12]) begin
      vv_r[12] <= ah_r[11] * b311_r;
    end
    if (rdy[13]) begin
      vv_r[13] <= vv_r[12];
      dsq13_r  <= dq13 * dq13;
    end
    if (rdy[14]) begin
      vv_r[14] <= vv_r[13];
      e14_r    <= (dsq13_r >>> 7) * h1_x;
    end
    if (rdy[15]) begin
      out_r.fine_temperature  <= fine_r[14];
      out_r.temperature_centi <= tc_r[14];
      out_r.humidity_q10      <= q15_nxt;
    end
    for (int k = 7; k <= 14; k++) begin
      if (rdy[k]) begin
        fine_r[k] <= fine_r[k-1];
        tc_r[k]   <= tc_r[k-1];
      end
    end
  end

  assign out_valid = v_r[NUM_STAGES];
  assign out_data  = out_r;

`ifndef SYNTH
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.humidity_q10 <= HUM_Q_MAX))
    else $error("humidity result above full scale");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("input blocked while a stage is empty");

  a_enter_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[1])
    else $error("accepted item did not reach the first stage");

  a_tail_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NUM_STAGES-1] && !out_valid) |=> out_valid)
    else $error("item failed to advance into the output stage");
`endif

endmodule

`default_nettype wire
